// File: src/cda_pkg.sv
// shared types, codes and calendar functions for the calendar date arithmetic block
`default_nettype none

package cda_pkg;

  localparam logic [13:0] YEAR_MAX = 14'd9999;

  typedef enum logic [2:0] {
    CMD_SET_DATE   = 3'd0,
    CMD_SET_YEAR   = 3'd1,
    CMD_SET_MONTH  = 3'd2,
    CMD_SET_DAY    = 3'd3,
    CMD_ADD_DAYS   = 3'd4,
    CMD_ADD_MONTHS = 3'd5,
    CMD_ADD_YEARS  = 3'd6,
    CMD_QUERY      = 3'd7
  } cmd_t;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_BAD = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [13:0] value_year;
    logic [3:0]  value_month;
    logic [4:0]  value_day;
    logic [15:0] amount;
  } in_t;

  typedef struct packed {
    logic [13:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [2:0]  weekday;
    logic [1:0]  status;
  } out_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_PREP,
    DP_MYEAR,
    DP_YCHK,
    DP_APPLY,
    DP_WALK,
    DP_ZOP,
    DP_ZSUM,
    DP_ZMUL,
    DP_EMIT
  } dp_op_t;

  typedef struct packed {
    cmd_t cmd;
    logic n_zero;
    logic fits;
    logic last_mon;
    logic at_max;
    logic y_ovf;
  } sts_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_MYEAR,
    S_YCHK,
    S_LW1,
    S_LW2,
    S_APPLY,
    S_WALK,
    S_WW1,
    S_WW2,
    S_ZOP,
    S_ZW1,
    S_ZW2,
    S_ZSUM,
    S_ZMUL,
    S_EMIT
  } state_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:                                        len = leap ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic date_ok(input logic [13:0] y, input logic [3:0] m,
                                   input logic [4:0] d, input logic leap);
    logic ok;
    ok = (y <= YEAR_MAX) && (m >= 4'd1) && (m <= 4'd12) && (d != 5'd0) &&
         (d <= month_len(m, leap));
    return ok;
  endfunction

  // floor(13 * (mm + 1) / 5) with january and february as months 13 and 14
  function automatic logic [5:0] zel_term(input logic [3:0] m);
    logic [5:0] t;
    case (m)
      4'd1:    t = 6'd36;
      4'd2:    t = 6'd39;
      4'd3:    t = 6'd10;
      4'd4:    t = 6'd13;
      4'd5:    t = 6'd15;
      4'd6:    t = 6'd18;
      4'd7:    t = 6'd20;
      4'd8:    t = 6'd23;
      4'd9:    t = 6'd26;
      4'd10:   t = 6'd28;
      4'd11:   t = 6'd31;
      4'd12:   t = 6'd33;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

// File: src/cda_ctrl.sv
// controller state machine sequencing each command through the datapath
`default_nettype none

module cda_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire cda_pkg::sts_t  sts,
  output logic                busy,
  output cda_pkg::dp_op_t     op
);
  import cda_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_PREP;
      end
      S_PREP: begin
        case (sts.cmd)
          CMD_ADD_MONTHS: state_nxt = S_MYEAR;
          CMD_ADD_YEARS:  state_nxt = S_YCHK;
          default:        state_nxt = S_LW1;
        endcase
      end
      S_MYEAR: state_nxt = S_YCHK;
      S_YCHK: begin
        state_nxt = sts.y_ovf ? S_ZOP : S_LW1;
      end
      S_LW1:   state_nxt = S_LW2;
      S_LW2:   state_nxt = S_APPLY;
      S_APPLY: begin
        state_nxt = (sts.cmd == CMD_ADD_DAYS) ? S_WALK : S_ZOP;
      end
      S_WALK: begin
        if (sts.n_zero || sts.fits) begin
          state_nxt = S_ZOP;
        end else if (sts.last_mon) begin
          state_nxt = sts.at_max ? S_ZOP : S_WW1;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_WW1:  state_nxt = S_WW2;
      S_WW2:  state_nxt = S_WALK;
      S_ZOP:  state_nxt = S_ZW1;
      S_ZW1:  state_nxt = S_ZW2;
      S_ZW2:  state_nxt = S_ZSUM;
      S_ZSUM: state_nxt = S_ZMUL;
      S_ZMUL: state_nxt = S_EMIT;
      S_EMIT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    busy = (state_r != S_IDLE);
    case (state_r)
      S_IDLE:  op = start ? DP_LOAD : DP_NOP;
      S_PREP:  op = DP_PREP;
      S_MYEAR: op = DP_MYEAR;
      S_YCHK:  op = DP_YCHK;
      S_APPLY: op = DP_APPLY;
      S_WALK:  op = DP_WALK;
      S_ZOP:   op = DP_ZOP;
      S_ZSUM:  op = DP_ZSUM;
      S_ZMUL:  op = DP_ZMUL;
      S_EMIT:  op = DP_EMIT;
      default: op = DP_NOP;
    endcase
  end

endmodule

`default_nettype wire

// File: src/cda_dp.sv
// datapath: date registers, leap year and year split unit, month walk and weekday
`default_nettype none

module cda_dp (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire cda_pkg::dp_op_t op,
  input  wire cda_pkg::in_t   in_item,
  output cda_pkg::sts_t       sts,
  output cda_pkg::out_t       out_item,
  output logic                out_strobe
);
  import cda_pkg::*;

  in_t         in_r;
  logic [13:0] cur_year_r;
  logic [3:0]  cur_month_r;
  logic [4:0]  cur_day_r;
  logic [13:0] op_year_r;
  logic [26:0] prod_r;
  logic [13:0] opd_r;
  logic        leap_r;
  logic [6:0]  k_r;
  logic [7:0]  j_r;
  logic [16:0] idx_r;
  logic [33:0] mprod_r;
  logic [16:0] ysum_r;
  logic [3:0]  mon_r;
  logic [15:0] n_r;
  logic [1:0]  st_r;
  logic [10:0] zsum_r;
  logic [24:0] zprod_r;
  out_t        out_r;
  logic        strobe_r;

  // year split by 100
  logic [7:0]  q100;
  logic [13:0] rem100;
  logic        leap_nxt;

  assign q100     = prod_r[26:19];
  assign rem100   = opd_r - ({6'b0, q100} * 14'd100);
  assign leap_nxt = ((opd_r[1:0] == 2'd0) && (rem100 != 14'd0)) ||
                    ((rem100 == 14'd0) && (q100[1:0] == 2'd0));

  always_ff @(posedge clk) begin
    prod_r <= {13'b0, op_year_r} * 27'd5243;
    opd_r  <= op_year_r;
    leap_r <= leap_nxt;
    k_r    <= rem100[6:0];
    j_r    <= q100;
  end

  // month index split by 12
  logic [16:0] idx;
  logic [13:0] q12;
  logic [16:0] r12;

  assign idx = {13'b0, cur_month_r} - 17'd1 + {1'b0, in_r.amount};
  assign q12 = mprod_r[33:20];
  assign r12 = idx_r - ({3'b0, q12} * 17'd12);

  // month walk
  logic [4:0]  wlen;
  logic [16:0] day_sum;
  logic [15:0] step;
  logic        n_zero;
  logic        fits;
  logic        last_mon;
  logic        at_max;
  logic        y_ovf;

  assign wlen     = month_len(cur_month_r, leap_r);
  assign day_sum  = {12'b0, cur_day_r} + {1'b0, n_r};
  assign step     = {11'b0, wlen} - {11'b0, cur_day_r} + 16'd1;
  assign n_zero   = (n_r == 16'd0);
  assign fits     = (day_sum <= {12'b0, wlen});
  assign last_mon = (cur_month_r == 4'd12);
  assign at_max   = (cur_year_r >= YEAR_MAX);
  assign y_ovf    = (ysum_r > {3'b0, YEAR_MAX});

  assign sts.cmd      = cmd_t'(in_r.cmd);
  assign sts.n_zero   = n_zero;
  assign sts.fits     = fits;
  assign sts.last_mon = last_mon;
  assign sts.at_max   = at_max;
  assign sts.y_ovf    = y_ovf;

  // weekday
  logic [8:0]  q7;
  logic [10:0] h7;
  logic [2:0]  wd;
  logic [10:0] zsum_nxt;
  logic [4:0]  amlen;

  assign q7 = zprod_r[24:16];
  assign h7 = zsum_r - ({2'b0, q7} * 11'd7);
  assign wd = (h7[2:0] == 3'd0) ? 3'd6 : (h7[2:0] - 3'd1);
  assign zsum_nxt = {6'b0, cur_day_r} + {5'b0, zel_term(cur_month_r)} + {4'b0, k_r} +
                    {6'b0, k_r[6:2]} + {5'b0, j_r[7:2]} + {1'b0, j_r, 2'b0} +
                    {3'b0, j_r};
  assign amlen = month_len(mon_r, leap_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_year_r  <= 14'd0;
      cur_month_r <= 4'd1;
      cur_day_r   <= 5'd1;
      op_year_r   <= 14'd0;
    end else begin
      case (op)
        DP_PREP: begin
          case (in_r.cmd)
            CMD_SET_DATE, CMD_SET_YEAR: op_year_r <= in_r.value_year;
            default:                    op_year_r <= cur_year_r;
          endcase
        end
        DP_YCHK: begin
          if (y_ovf) begin
            cur_year_r  <= YEAR_MAX;
            cur_month_r <= 4'd12;
            cur_day_r   <= 5'd31;
          end else begin
            op_year_r <= ysum_r[13:0];
          end
        end
        DP_APPLY: begin
          case (in_r.cmd)
            CMD_SET_DATE: begin
              if (date_ok(in_r.value_year, in_r.value_month, in_r.value_day, leap_r)) begin
                cur_year_r  <= in_r.value_year;
                cur_month_r <= in_r.value_month;
                cur_day_r   <= in_r.value_day;
              end else begin
                cur_year_r  <= 14'd0;
                cur_month_r <= 4'd1;
                cur_day_r   <= 5'd1;
              end
            end
            CMD_SET_YEAR: begin
              if (date_ok(in_r.value_year, cur_month_r, cur_day_r, leap_r)) begin
                cur_year_r <= in_r.value_year;
              end
            end
            CMD_SET_MONTH: begin
              if (date_ok(cur_year_r, in_r.value_month, cur_day_r, leap_r)) begin
                cur_month_r <= in_r.value_month;
              end
            end
            CMD_SET_DAY: begin
              if (date_ok(cur_year_r, cur_month_r, in_r.value_day, leap_r)) begin
                cur_day_r <= in_r.value_day;
              end
            end
            CMD_ADD_MONTHS: begin
              cur_year_r  <= ysum_r[13:0];
              cur_month_r <= mon_r;
              if (cur_day_r > amlen) cur_day_r <= amlen;
            end
            CMD_ADD_YEARS: begin
              cur_year_r <= ysum_r[13:0];
              if ((cur_month_r == 4'd2) && (cur_day_r == 5'd29) && !leap_r) begin
                cur_day_r <= 5'd28;
              end
            end
            default: begin
            end
          endcase
        end
        DP_WALK: begin
          if (n_zero || fits) begin
            cur_day_r <= day_sum[4:0];
          end else if (last_mon) begin
            if (at_max) begin
              cur_year_r  <= YEAR_MAX;
              cur_month_r <= 4'd12;
              cur_day_r   <= 5'd31;
            end else begin
              cur_day_r   <= 5'd1;
              cur_month_r <= 4'd1;
              cur_year_r  <= cur_year_r + 14'd1;
              op_year_r   <= cur_year_r + 14'd1;
            end
          end else begin
            cur_day_r   <= 5'd1;
            cur_month_r <= cur_month_r + 4'd1;
          end
        end
        DP_ZOP: begin
          op_year_r <= cur_year_r + 14'd400 - ((cur_month_r < 4'd3) ? 14'd1 : 14'd0);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      DP_LOAD: in_r <= in_item;
      DP_PREP: begin
        st_r    <= ST_OK;
        idx_r   <= idx;
        mprod_r <= {17'b0, idx} * 34'd87382;
        ysum_r  <= {3'b0, cur_year_r} + {1'b0, in_r.amount};
      end
      DP_MYEAR: begin
        mon_r  <= r12[3:0] + 4'd1;
        ysum_r <= {3'b0, cur_year_r} + {3'b0, q12};
      end
      DP_YCHK: begin
        if (y_ovf) st_r <= ST_OVF;
      end
      DP_APPLY: begin
        n_r <= in_r.amount;
        case (in_r.cmd)
          CMD_SET_DATE: begin
            if (!date_ok(in_r.value_year, in_r.value_month, in_r.value_day, leap_r)) begin
              st_r <= ST_BAD;
            end
          end
          CMD_SET_YEAR: begin
            if (!date_ok(in_r.value_year, cur_month_r, cur_day_r, leap_r)) st_r <= ST_BAD;
          end
          CMD_SET_MONTH: begin
            if (!date_ok(cur_year_r, in_r.value_month, cur_day_r, leap_r)) st_r <= ST_BAD;
          end
          CMD_SET_DAY: begin
            if (!date_ok(cur_year_r, cur_month_r, in_r.value_day, leap_r)) st_r <= ST_BAD;
          end
          default: begin
          end
        endcase
      end
      DP_WALK: begin
        if (n_zero || fits) begin
          n_r <= 16'd0;
        end else begin
          n_r <= n_r - step;
          if (last_mon && at_max) st_r <= ST_OVF;
        end
      end
      DP_ZSUM: zsum_r <= zsum_nxt;
      DP_ZMUL: zprod_r <= {14'b0, zsum_r} * 25'd9363;
      DP_EMIT: begin
        out_r.out_year  <= cur_year_r;
        out_r.out_month <= cur_month_r;
        out_r.out_day   <= cur_day_r;
        out_r.weekday   <= wd;
        out_r.status    <= st_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= (op == DP_EMIT);
    end
  end

  assign out_item   = out_r;
  assign out_strobe = strobe_r;

endmodule

`default_nettype wire

// File: src/calendar_date_arithmetic.sv
// top level of the calendar date arithmetic block
`default_nettype none

// Gregorian date register with set, add and query commands. A command is taken
// when start is high and busy is low; its single result (date, weekday with 0 as
// Sunday, status) appears on out_item for exactly one cycle with out_strobe high,
// and the receiver cannot stall it. Sets and queries pass through the two-stage
// leap year unit and the two-stage weekday computation, and adds of months or years
// also pass the year overflow check; an add of months or years that overflows
// skips the leap year wait and the apply step. Add days walks one month per cycle,
// but at every year boundary it waits in S_WW1 and S_WW2 to refresh the leap year
// unit. busy stays high until the strobe cycle.
module calendar_date_arithmetic (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  input  wire cda_pkg::in_t in_item,
  output cda_pkg::out_t     out_item,
  output logic              out_strobe
);
  import cda_pkg::*;

  dp_op_t op;
  sts_t   sts;

  cda_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .op    (op)
  );

  cda_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (op),
    .in_item    (in_item),
    .sts        (sts),
    .out_item   (out_item),
    .out_strobe (out_strobe)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (!busy && !$past(out_strobe)))
    else $error("result strobe while busy or repeated");

  a_valid_date: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ((out_item.out_month >= 4'd1) && (out_item.out_month <= 4'd12) &&
                    (out_item.out_day != 5'd0) && (out_item.out_year <= YEAR_MAX) &&
                    (out_item.weekday <= 3'd6)))
    else $error("result date or weekday out of range");

  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_item.status == ST_OVF)) |->
      ((out_item.out_year == YEAR_MAX) && (out_item.out_month == 4'd12) &&
       (out_item.out_day == 5'd31)))
    else $error("overflow status without saturated date");

endmodule

`default_nettype wire

// File: test/cda_checker.sv
// checker for the calendar date block: predicts each result and compares it
`default_nettype none

module cda_checker (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          busy,
  input  wire cda_pkg::in_t  in_item,
  input  wire cda_pkg::out_t out_item,
  input  wire logic          out_strobe,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import cda_pkg::*;

  int   cal_year;
  int   cal_month;
  int   cal_day;
  out_t expected_dates[$];
  out_t want;

  initial begin
    fail_count = 0;
    pending    = 0;
    cal_year   = 0;
    cal_month  = 1;
    cal_day    = 1;
  end

  function automatic bit leap_year(input int y);
    return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
  endfunction

  function automatic int days_in(input int m, input int y);
    int len;
    case (m)
      1, 3, 5, 7, 8, 10, 12: len = 31;
      4, 6, 9, 11:           len = 30;
      2:                     len = leap_year(y) ? 29 : 28;
      default:               len = 0;
    endcase
    return len;
  endfunction

  function automatic bit valid_date(input int y, input int m, input int d);
    return (y <= YEAR_MAX) && (m >= 1) && (m <= 12) && (d >= 1) && (d <= days_in(m, y));
  endfunction

  // zeller with the year shifted by one 400-year cycle to keep division floored
  function automatic int weekday_of(input int y, input int m, input int d);
    int yy;
    int mm;
    int k;
    int j;
    int h;
    yy = y + 400;
    mm = m;
    if (mm < 3) begin
      mm = mm + 12;
      yy = yy - 1;
    end
    k = yy % 100;
    j = yy / 100;
    h = (d + (13 * (mm + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
    return (h + 6) % 7;
  endfunction

  task automatic saturate_date();
    cal_year  = YEAR_MAX;
    cal_month = 12;
    cal_day   = 31;
  endtask

  task automatic predict_date(input in_t it, output out_t res);
    logic [1:0] st;
    int         n;
    int         len;
    int         idx;
    int         y;
    st = ST_OK;
    case (cmd_t'(it.cmd))
      CMD_SET_DATE: begin
        if (valid_date(it.value_year, it.value_month, it.value_day)) begin
          cal_year  = it.value_year;
          cal_month = it.value_month;
          cal_day   = it.value_day;
        end else begin
          cal_year  = 0;
          cal_month = 1;
          cal_day   = 1;
          st        = ST_BAD;
        end
      end
      CMD_SET_YEAR: begin
        if (valid_date(it.value_year, cal_month, cal_day)) cal_year = it.value_year;
        else st = ST_BAD;
      end
      CMD_SET_MONTH: begin
        if (valid_date(cal_year, it.value_month, cal_day)) cal_month = it.value_month;
        else st = ST_BAD;
      end
      CMD_SET_DAY: begin
        if (valid_date(cal_year, cal_month, it.value_day)) cal_day = it.value_day;
        else st = ST_BAD;
      end
      CMD_ADD_DAYS: begin
        n = it.amount;
        while (n > 0) begin
          len = days_in(cal_month, cal_year);
          if (cal_day + n <= len) begin
            cal_day = cal_day + n;
            n = 0;
          end else begin
            n = n - (len - cal_day + 1);
            cal_day = 1;
            if (cal_month == 12) begin
              if (cal_year >= YEAR_MAX) begin
                saturate_date();
                st = ST_OVF;
                n = 0;
              end else begin
                cal_month = 1;
                cal_year  = cal_year + 1;
              end
            end else begin
              cal_month = cal_month + 1;
            end
          end
        end
      end
      CMD_ADD_MONTHS: begin
        idx = (cal_month - 1) + it.amount;
        y   = cal_year + idx / 12;
        if (y > YEAR_MAX) begin
          saturate_date();
          st = ST_OVF;
        end else begin
          cal_year  = y;
          cal_month = idx % 12 + 1;
          len = days_in(cal_month, cal_year);
          if (cal_day > len) cal_day = len;
        end
      end
      CMD_ADD_YEARS: begin
        y = cal_year + it.amount;
        if (y > YEAR_MAX) begin
          saturate_date();
          st = ST_OVF;
        end else begin
          cal_year = y;
          if (cal_month == 2 && cal_day == 29 && !leap_year(cal_year)) cal_day = 28;
        end
      end
      default: ;
    endcase
    res.out_year  = cal_year[13:0];
    res.out_month = cal_month[3:0];
    res.out_day   = cal_day[4:0];
    res.weekday   = 3'(weekday_of(cal_year, cal_month, cal_day));
    res.status    = st;
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    fail_count = fail_count + 1;
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, exp_val));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cal_year  = 0;
      cal_month = 1;
      cal_day   = 1;
      expected_dates.delete();
    end else begin
      if (out_strobe) begin
        if (expected_dates.size() == 0) begin
          report_mismatch($sformatf("result %0d-%0d-%0d with no item pending",
                                    out_item.out_year, out_item.out_month, out_item.out_day));
        end else begin
          want = expected_dates.pop_front();
          compare_field("year", 16'(out_item.out_year), 16'(want.out_year));
          compare_field("month", 16'(out_item.out_month), 16'(want.out_month));
          compare_field("day", 16'(out_item.out_day), 16'(want.out_day));
          compare_field("weekday", 16'(out_item.weekday), 16'(want.weekday));
          compare_field("status", 16'(out_item.status), 16'(want.status));
        end
      end
      if (start && !busy) begin
        predict_date(in_item, want);
        expected_dates.push_back(want);
      end
    end
    pending = expected_dates.size();
  end

endmodule

`default_nettype wire

// File: test/tb_calendar_date_arithmetic.sv
// testbench top for the calendar date block: reset, command stimulus and verdict
`default_nettype none

module tb_calendar_date_arithmetic;
  timeunit 1ns;
  timeprecision 1ps;

  import cda_pkg::*;

  localparam int     RUN_ITEMS   = 242;
  localparam longint CYCLE_LIMIT = 4000000;

  logic   clk = 1'b0;
  logic   rst_n;
  logic   start;
  logic   busy;
  in_t    in_item;
  out_t   out_item;
  logic   out_strobe;
  int     fail_count;
  int     pending;
  longint cycle_count = 0;
  bit     no_gaps = 1'b0;
  int     special_years[8] = '{0, 4, 100, 400, 1900, 2000, 9996, 9999};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  calendar_date_arithmetic u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_item   (out_item),
    .out_strobe (out_strobe)
  );

  cda_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_item   (out_item),
    .out_strobe (out_strobe),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic in_t make_item(input cmd_t c, input int y, input int m, input int d,
                                    input int amt);
    in_t it;
    it.cmd         = c;
    it.value_year  = y[13:0];
    it.value_month = m[3:0];
    it.value_day   = d[4:0];
    it.amount      = amt[15:0];
    return it;
  endfunction

  function automatic int pick_year();
    int r;
    int y;
    r = $urandom_range(0, 9);
    if (r == 0) y = special_years[$urandom_range(0, 7)];
    else if (r == 1) y = $urandom_range(9900, 9999);
    else y = $urandom_range(0, 9999);
    return y;
  endfunction

  function automatic int pick_amount(input int common_hi, input int mid_hi);
    int r;
    int a;
    r = $urandom_range(0, 99);
    if (r < 80) a = $urandom_range(0, common_hi);
    else if (r < 95) a = $urandom_range(0, mid_hi);
    else a = $urandom_range(0, 65535);
    return a;
  endfunction

  // holds the item until the block takes it
  task automatic send_cmd(input in_t it);
    in_item <= it;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) n = 0;
    else if (r < 85) n = $urandom_range(1, 3);
    else if (r < 95) n = $urandom_range(4, 12);
    else n = $urandom_range(20, 80);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic run_cmd(input cmd_t c, input int y, input int m, input int d,
                         input int amt);
    send_cmd(make_item(c, y, m, d, amt));
    idle_gap();
  endtask

  initial begin
    int r;
    int y;
    int m;
    int d;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed corners
    run_cmd(CMD_QUERY, 16383, 15, 31, 65535);
    run_cmd(CMD_QUERY, 0, 0, 0, 0);
    run_cmd(CMD_SET_DATE, 2024, 2, 29, $urandom);
    run_cmd(CMD_SET_YEAR, 2023, $urandom, $urandom, $urandom);
    run_cmd(CMD_SET_YEAR, 2000, $urandom, $urandom, $urandom);
    run_cmd(CMD_SET_YEAR, 10000, $urandom, $urandom, $urandom);
    run_cmd(CMD_SET_MONTH, $urandom, 4, $urandom, $urandom);
    run_cmd(CMD_SET_DAY, $urandom, $urandom, 31, $urandom);
    run_cmd(CMD_SET_DAY, $urandom, $urandom, 0, $urandom);
    run_cmd(CMD_SET_MONTH, $urandom, 0, $urandom, $urandom);
    run_cmd(CMD_SET_MONTH, $urandom, 15, $urandom, $urandom);
    run_cmd(CMD_SET_DATE, 16383, 15, 31, 65535);
    run_cmd(CMD_SET_DATE, 2023, 2, 29, 0);
    run_cmd(CMD_SET_DATE, 0, 2, 29, $urandom);
    run_cmd(CMD_ADD_YEARS, $urandom, $urandom, $urandom, 1);
    run_cmd(CMD_SET_DATE, 2000, 1, 31, $urandom);
    run_cmd(CMD_ADD_MONTHS, $urandom, $urandom, $urandom, 1);
    run_cmd(CMD_ADD_MONTHS, $urandom, $urandom, $urandom, 0);
    run_cmd(CMD_ADD_DAYS, $urandom, $urandom, $urandom, 0);
    run_cmd(CMD_ADD_YEARS, $urandom, $urandom, $urandom, 0);
    run_cmd(CMD_SET_DATE, 9999, 12, 31, $urandom);
    run_cmd(CMD_ADD_DAYS, $urandom, $urandom, $urandom, 1);
    run_cmd(CMD_ADD_MONTHS, $urandom, $urandom, $urandom, 1);
    run_cmd(CMD_ADD_YEARS, $urandom, $urandom, $urandom, 1);
    run_cmd(CMD_SET_DATE, 0, 1, 1, $urandom);
    run_cmd(CMD_ADD_DAYS, $urandom, $urandom, $urandom, 65535);
    run_cmd(CMD_ADD_MONTHS, $urandom, $urandom, $urandom, 65535);
    run_cmd(CMD_ADD_YEARS, $urandom, $urandom, $urandom, 65535);

    for (int i = 0; i < RUN_ITEMS; i++) begin
      no_gaps = (i >= 100 && i < 140);
      r = $urandom_range(0, 99);
      if (r < 15) begin
        y = pick_year();
        m = $urandom_range(1, 12);
        d = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 31) : $urandom_range(1, 28);
        run_cmd(CMD_SET_DATE, y, m, d, $urandom);
      end else if (r < 20) begin
        run_cmd(cmd_t'($urandom_range(0, 7)), $urandom, $urandom, $urandom, $urandom);
      end else if (r < 28) begin
        y = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383) : pick_year();
        run_cmd(CMD_SET_YEAR, y, $urandom, $urandom, $urandom);
      end else if (r < 36) begin
        run_cmd(CMD_SET_MONTH, $urandom, $urandom_range(0, 15), $urandom, $urandom);
      end else if (r < 44) begin
        run_cmd(CMD_SET_DAY, $urandom, $urandom, $urandom_range(0, 31), $urandom);
      end else if (r < 62) begin
        run_cmd(CMD_ADD_DAYS, $urandom, $urandom, $urandom, pick_amount(400, 5000));
      end else if (r < 76) begin
        run_cmd(CMD_ADD_MONTHS, $urandom, $urandom, $urandom, pick_amount(200, 2000));
      end else if (r < 88) begin
        run_cmd(CMD_ADD_YEARS, $urandom, $urandom, $urandom, pick_amount(50, 1000));
      end else begin
        run_cmd(CMD_QUERY, $urandom, $urandom, $urandom, $urandom);
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(negedge clk);
    repeat (30) @(posedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
src/cda_pkg.sv
src/cda_ctrl.sv
src/cda_dp.sv
src/calendar_date_arithmetic.sv
test/cda_checker.sv
test/tb_calendar_date_arithmetic.sv
